@@ rtl/core/srctok_pkg.sv @@
// ---------------------------------------------------------------------------
// Source tokenizer package
// Shared types, codes and character helpers for the source tokenizer.
// ---------------------------------------------------------------------------
package srctok_pkg;

	localparam int WORD_BYTES = 8;
	localparam logic [11:0] LEN_CAP = 12'd4095;

	// Scan modes.
	localparam logic [2:0] M_IDLE     = 3'd0;
	localparam logic [2:0] M_IDENT    = 3'd1;
	localparam logic [2:0] M_NUMBER   = 3'd2;
	localparam logic [2:0] M_STRING   = 3'd3;
	localparam logic [2:0] M_OPER     = 3'd4;
	localparam logic [2:0] M_LINECMT  = 3'd5;
	localparam logic [2:0] M_BLOCKCMT = 3'd6;

	// Token kinds.
	localparam logic [5:0] K_EOF    = 6'd0;
	localparam logic [5:0] K_IDENT  = 6'd1;
	localparam logic [5:0] K_TYPE   = 6'd2;
	localparam logic [5:0] K_BOOL   = 6'd3;
	localparam logic [5:0] K_INT    = 6'd17;
	localparam logic [5:0] K_FLOAT  = 6'd18;
	localparam logic [5:0] K_STRING = 6'd19;
	localparam logic [5:0] K_ERROR  = 6'd46;

	// Configuration register indexes.
	localparam logic CFG_FIRST_LINE   = 1'b0;
	localparam logic CFG_FIRST_COLUMN = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] source_byte;
	} in_word_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [3:0]  word_index;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [23:0] token_offset;
		logic [11:0] token_length;
		logic        last_of_run;
	} out_word_t;

	// Up to two tokens decided by one input word.
	typedef struct packed {
		logic      v0;
		logic      v1;
		out_word_t t0;
		out_word_t t1;
	} tok_pair_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic may_pair(input logic [7:0] c);
		return c == "=" || c == "+" || c == "-" || c == "*" || c == "!" ||
			c == "<" || c == ">" || c == "/";
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			";": k = 6'd22;
			",": k = 6'd23;
			"(": k = 6'd24;
			")": k = 6'd25;
			"{": k = 6'd26;
			"}": k = 6'd27;
			"[": k = 6'd28;
			"]": k = 6'd29;
			"&": k = 6'd35;
			"%": k = 6'd38;
			":": k = 6'd44;
			".": k = 6'd45;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] lone_kind(input logic [7:0] p);
		logic [5:0] k;
		case (p)
			"=": k = 6'd20;
			"+": k = 6'd30;
			"-": k = 6'd32;
			"*": k = 6'd35;
			"<": k = 6'd40;
			">": k = 6'd42;
			"/": k = 6'd37;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

	// Zero means no two-character operator.
	function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [5:0] k;
		k = 6'd0;
		if (p == "=" && c == "=") k = 6'd21;
		if (p == "+" && c == "+") k = 6'd31;
		if (p == "-" && c == ">") k = 6'd33;
		if (p == "-" && c == "-") k = 6'd34;
		if (p == "*" && c == "*") k = 6'd36;
		if (p == "!" && c == "=") k = 6'd39;
		if (p == "<" && c == "=") k = 6'd41;
		if (p == ">" && c == "=") k = 6'd43;
		return k;
	endfunction

endpackage

@@ rtl/core/srctok_word_match.sv @@
// ---------------------------------------------------------------------------
// Source tokenizer word match
// Parallel compare of a finished identifier against the 31 fixed words.
// ---------------------------------------------------------------------------
module srctok_word_match import srctok_pkg::*; (
	input  logic [63:0] prefix,
	input  logic [11:0] length,
	output logic [5:0]  kind,
	output logic [3:0]  index
);

	// Byte 0 of the word sits in the low byte of the prefix.
	function automatic logic hit(input logic [63:0] p, input logic [11:0] n,
		input logic [63:0] w, input logic [3:0] wl);
		return n == {8'd0, wl} && p == w;
	endfunction

	function automatic logic [63:0] pk(input string s);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < s.len(); i++) r[i*8 +: 8] = s[i];
		return r;
	endfunction

	always_comb begin
		kind = K_IDENT;
		index = 4'd0;
		if (hit(prefix, length, pk("let"), 4'd3)) kind = 6'd4;
		else if (hit(prefix, length, pk("fn"), 4'd2)) kind = 6'd5;
		else if (hit(prefix, length, pk("struct"), 4'd6)) kind = 6'd6;
		else if (hit(prefix, length, pk("return"), 4'd6)) kind = 6'd7;
		else if (hit(prefix, length, pk("for"), 4'd3)) kind = 6'd8;
		else if (hit(prefix, length, pk("while"), 4'd5)) kind = 6'd9;
		else if (hit(prefix, length, pk("if"), 4'd2)) kind = 6'd10;
		else if (hit(prefix, length, pk("else"), 4'd4)) kind = 6'd11;
		else if (hit(prefix, length, pk("switch"), 4'd6)) kind = 6'd12;
		else if (hit(prefix, length, pk("case"), 4'd4)) kind = 6'd13;
		else if (hit(prefix, length, pk("default"), 4'd7)) kind = 6'd14;
		else if (hit(prefix, length, pk("new"), 4'd3)) kind = 6'd15;
		else if (hit(prefix, length, pk("extern"), 4'd6)) kind = 6'd16;
		else if (hit(prefix, length, pk("true"), 4'd4)) begin kind = K_BOOL; index = 4'd1; end
		else if (hit(prefix, length, pk("false"), 4'd5)) kind = K_BOOL;
		else if (hit(prefix, length, pk("i8"), 4'd2)) kind = K_TYPE;
		else if (hit(prefix, length, pk("i16"), 4'd3)) begin kind = K_TYPE; index = 4'd1; end
		else if (hit(prefix, length, pk("i32"), 4'd3)) begin kind = K_TYPE; index = 4'd2; end
		else if (hit(prefix, length, pk("i64"), 4'd3)) begin kind = K_TYPE; index = 4'd3; end
		else if (hit(prefix, length, pk("u8"), 4'd2)) begin kind = K_TYPE; index = 4'd4; end
		else if (hit(prefix, length, pk("u16"), 4'd3)) begin kind = K_TYPE; index = 4'd5; end
		else if (hit(prefix, length, pk("u32"), 4'd3)) begin kind = K_TYPE; index = 4'd6; end
		else if (hit(prefix, length, pk("u64"), 4'd3)) begin kind = K_TYPE; index = 4'd7; end
		else if (hit(prefix, length, pk("f8"), 4'd2)) begin kind = K_TYPE; index = 4'd8; end
		else if (hit(prefix, length, pk("f16"), 4'd3)) begin kind = K_TYPE; index = 4'd9; end
		else if (hit(prefix, length, pk("f32"), 4'd3)) begin kind = K_TYPE; index = 4'd10; end
		else if (hit(prefix, length, pk("f64"), 4'd3)) begin kind = K_TYPE; index = 4'd11; end
		else if (hit(prefix, length, pk("bool"), 4'd4)) begin kind = K_TYPE; index = 4'd12; end
		else if (hit(prefix, length, pk("string"), 4'd6)) begin kind = K_TYPE; index = 4'd13; end
		else if (hit(prefix, length, pk("array"), 4'd5)) begin kind = K_TYPE; index = 4'd14; end
		else if (hit(prefix, length, pk("void"), 4'd4)) begin kind = K_TYPE; index = 4'd15; end
	end

endmodule

@@ rtl/core/srctok_scan.sv @@
// ---------------------------------------------------------------------------
// Source tokenizer scanner
// Holds the scan state and decides the tokens caused by one input word.
// ---------------------------------------------------------------------------
module srctok_scan import srctok_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_word_t    in_word,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_val,
	output tok_pair_t   toks
);

	logic [2:0]  mode_q;
	logic [7:0]  pend_q;
	logic [63:0] prefix_q;
	logic [11:0] len_q;
	logic        dot_q;
	logic [15:0] sline_q, scol_q, cline_q, ccol_q, fline_q, fcol_q;
	logic [23:0] soff_q, coff_q;

	logic [5:0] wm_kind;
	logic [3:0] wm_idx;

	srctok_word_match u_match (
		.prefix(prefix_q),
		.length(len_q),
		.kind  (wm_kind),
		.index (wm_idx)
	);

	logic [2:0]  mode_d;
	logic [7:0]  pend_d;
	logic [63:0] prefix_d;
	logic [11:0] len_d;
	logic        dot_d;
	logic [15:0] sline_d, scol_d;
	logic [23:0] soff_d;
	logic [7:0]  c;
	logic        flush_v, begin_v, begin_tok;
	out_word_t   flush_t, begin_t;
	logic [11:0] len_inc;
	logic [5:0]  pk;

	assign c = in_word.source_byte;
	assign len_inc = (len_q < LEN_CAP) ? len_q + 12'd1 : len_q;

	// Token that the open scan would produce if closed now.
	always_comb begin
		flush_t = '0;
		flush_t.token_line = sline_q;
		flush_t.token_column = scol_q;
		flush_t.token_offset = soff_q;
		flush_t.token_length = len_q;
		flush_v = 1'b1;
		case (mode_q)
			M_IDENT: begin
				flush_t.token_kind = wm_kind;
				flush_t.word_index = wm_idx;
			end
			M_NUMBER: flush_t.token_kind = dot_q ? K_FLOAT : K_INT;
			M_STRING: flush_t.token_kind = K_STRING;
			M_OPER: begin
				flush_t.token_kind = lone_kind(pend_q);
				flush_t.token_length = 12'd1;
			end
			default: flush_v = 1'b0;
		endcase
	end

	// Next state and tokens.
	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		prefix_d = prefix_q;
		len_d = len_q;
		dot_d = dot_q;
		sline_d = sline_q;
		scol_d = scol_q;
		soff_d = soff_q;
		toks = '0;
		begin_v = 1'b0;
		begin_tok = 1'b0;
		begin_t = '0;
		pk = pair_kind(pend_q, c);
		if (in_word.op) begin
			toks.v0 = flush_v;
			toks.t0 = flush_t;
			toks.v1 = 1'b1;
			toks.t1.token_kind = K_EOF;
			toks.t1.token_line = cline_q;
			toks.t1.token_column = ccol_q;
			toks.t1.token_offset = coff_q;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						if (len_q < 12'(WORD_BYTES)) prefix_d[len_q[2:0]*8 +: 8] = c;
						len_d = len_inc;
					end else begin
						toks.v0 = 1'b1;
						toks.t0 = flush_t;
						begin_v = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(c) || (c == "." && !dot_q)) begin
						if (c == ".") dot_d = 1'b1;
						len_d = len_inc;
					end else begin
						toks.v0 = 1'b1;
						toks.t0 = flush_t;
						begin_v = 1'b1;
					end
				end
				M_STRING: begin
					if (c == "\"") begin
						toks.v0 = 1'b1;
						toks.t0 = flush_t;
						mode_d = M_IDLE;
					end else begin
						len_d = len_inc;
					end
				end
				M_LINECMT: if (c == 8'd10) mode_d = M_IDLE;
				M_BLOCKCMT: begin
					if (dot_q && c == "/") begin
						mode_d = M_IDLE;
						dot_d = 1'b0;
					end else begin
						dot_d = (c == "*");
					end
				end
				M_OPER: begin
					if (pk != 6'd0) begin
						toks.v0 = 1'b1;
						toks.t0 = flush_t;
						toks.t0.token_kind = pk;
						toks.t0.token_length = 12'd2;
						mode_d = M_IDLE;
						pend_d = 8'd0;
					end else if (pend_q == "/" && c == "/") begin
						mode_d = M_LINECMT;
						pend_d = 8'd0;
					end else if (pend_q == "/" && c == "*") begin
						mode_d = M_BLOCKCMT;
						pend_d = 8'd0;
						dot_d = 1'b1;
					end else begin
						toks.v0 = 1'b1;
						toks.t0 = flush_t;
						begin_v = 1'b1;
					end
				end
				default: begin_v = 1'b1;
			endcase
			// Start a new token with this byte.
			if (begin_v) begin
				mode_d = M_IDLE;
				pend_d = 8'd0;
				dot_d = 1'b0;
				sline_d = cline_q;
				scol_d = ccol_q;
				soff_d = coff_q;
				if (is_space(c)) begin
				end else if (is_alpha(c) || c == "_") begin
					mode_d = M_IDENT;
					prefix_d = {56'd0, c};
					len_d = 12'd1;
				end else if (is_digit(c)) begin
					mode_d = M_NUMBER;
					len_d = 12'd1;
				end else if (c == "\"") begin
					mode_d = M_STRING;
					len_d = 12'd0;
				end else if (may_pair(c)) begin
					mode_d = M_OPER;
					pend_d = c;
				end else begin
					begin_tok = 1'b1;
					begin_t.token_kind = single_kind(c);
					begin_t.token_line = cline_q;
					begin_t.token_column = ccol_q;
					begin_t.token_offset = coff_q;
					begin_t.token_length = 12'd1;
				end
			end
			if (begin_tok) begin
				if (toks.v0) begin
					toks.v1 = 1'b1;
					toks.t1 = begin_t;
				end else begin
					toks.v0 = 1'b1;
					toks.t0 = begin_t;
				end
			end
		end
		// Mark the last token of the run.
		if (toks.v1) toks.t1.last_of_run = 1'b1;
		else if (toks.v0) toks.t0.last_of_run = 1'b1;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			prefix_q <= '0;
			len_q <= '0;
			dot_q <= 1'b0;
			sline_q <= '0;
			scol_q <= '0;
			soff_q <= '0;
			cline_q <= 16'd1;
			ccol_q <= 16'd1;
			coff_q <= '0;
			fline_q <= 16'd1;
			fcol_q <= 16'd1;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_FIRST_LINE) begin
				fline_q <= cfg_val;
				if (coff_q == '0) cline_q <= cfg_val;
			end else begin
				fcol_q <= cfg_val;
				if (coff_q == '0) ccol_q <= cfg_val;
			end
		end else if (step) begin
			if (in_word.op) begin
				mode_q <= M_IDLE;
				pend_q <= '0;
				prefix_q <= '0;
				len_q <= '0;
				dot_q <= 1'b0;
				sline_q <= '0;
				scol_q <= '0;
				soff_q <= '0;
				cline_q <= fline_q;
				ccol_q <= fcol_q;
				coff_q <= '0;
			end else begin
				mode_q <= mode_d;
				pend_q <= pend_d;
				prefix_q <= prefix_d;
				len_q <= len_d;
				dot_q <= dot_d;
				sline_q <= sline_d;
				scol_q <= scol_d;
				soff_q <= soff_d;
				if (c == 8'd10) begin
					if (cline_q != 16'hFFFF) cline_q <= cline_q + 16'd1;
					ccol_q <= fcol_q;
				end else if (ccol_q != 16'hFFFF) begin
					ccol_q <= ccol_q + 16'd1;
				end
				if (coff_q != 24'hFFFFFF) coff_q <= coff_q + 24'd1;
			end
		end
	end

endmodule

@@ rtl/core/srctok_out_queue.sv @@
// ---------------------------------------------------------------------------
// Source tokenizer output queue
// Four-entry FIFO: takes up to two tokens a cycle, gives one when out_ready.
// ---------------------------------------------------------------------------
module srctok_out_queue import srctok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tok_pair_t toks,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	out_word_t   mem_q [4];
	logic [1:0]  rd_q, wr_q;
	logic [2:0]  cnt_q;
	logic        pop, w0, w1;

	assign out_valid = cnt_q != 3'd0;
	assign out_word = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	// Room for two more words whatever leaves this cycle.
	assign room = cnt_q <= 3'd2;
	assign w0 = push && (toks.v0 || toks.v1);
	assign w1 = push && toks.v0 && toks.v1;

	// Storage; a lone token always lands in the first free slot.
	always_ff @(posedge clk) begin
		if (w0) mem_q[wr_q] <= toks.v0 ? toks.t0 : toks.t1;
		if (w1) mem_q[wr_q + 2'd1] <= toks.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 2'd1;
			wr_q <= wr_q + (w1 ? 2'd2 : (w0 ? 2'd1 : 2'd0));
			cnt_q <= cnt_q + (w1 ? 3'd2 : (w0 ? 3'd1 : 3'd0)) - {2'b0, pop};
		end
	end

endmodule

@@ rtl/core/source_tokenizer_unit.sv @@
// ---------------------------------------------------------------------------
// Source tokenizer unit
// Streaming lexer: one source byte per word in, tokens out.
// ---------------------------------------------------------------------------
// One input word is taken per cycle while the four-word token queue has room
// for two tokens and no config write is offered; a word may produce up to two
// tokens, which leave one per cycle, so the sustained rate is one byte per
// cycle unless the token stream outruns the output side. The scan state
// registers update in the accepting cycle and tokens are readable from the queue on the next cycle.
module source_tokenizer_unit import srctok_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	tok_pair_t toks;
	logic      room, step, cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid;
	assign in_ready = room && !cfg_valid;
	assign step = in_valid && in_ready;

	srctok_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.in_word(in_data),
		.cfg_we (cfg_we),
		.cfg_idx(cfg_index),
		.cfg_val(cfg_data),
		.toks   (toks)
	);

	srctok_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step),
		.toks     (toks),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_data)
	);

endmodule
